// ----- hw/rtl/lss_pkg.sv -----
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, codes, types and helpers for the byte stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

    // Stack geometry.
    localparam int DEPTH  = 8;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Request kinds.
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_PEEK   = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       start;     // latch the request and read the top entry
        logic       push;      // write the request byte and bump the fill count
        logic       pop;       // drop the top entry
        logic       step;      // move the scan one entry down
        logic       res_load;  // capture a result
        logic [1:0] res_status;
        logic       res_data;  // result data comes from the read register
        logic       res_pos;   // result position comes from the scan counter
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic match;  // current read entry equals the searched byte
        logic last;   // the scan is at the bottom entry
    } stat_t;

    // Fit a count into a 4-bit output field, masking the upper bits.
    function automatic logic [3:0] to_nibble(input cnt_t v);
        logic [31:0] wide;
        wide = 32'(v);
        return wide[3:0];
    endfunction

endpackage

// ----- hw/rtl/lss_dp.sv -----
// ----------------------------------------------------------------------------
// lss_dp
// Datapath: entry storage, fill count, scan counter and result registers.
// ----------------------------------------------------------------------------
module lss_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       value,
    input  lss_pkg::cmd_t    cmd,
    output lss_pkg::stat_t   stat,
    output logic [1:0]       status,
    output logic [7:0]       data,
    output logic [3:0]       position,
    output logic [3:0]       fill
);
    import lss_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_reg;
    logic [7:0] value_reg;
    cnt_t       fill_reg, fill_next;
    cnt_t       cur_reg, cur_next;
    logic [1:0] status_reg;
    logic [7:0] data_reg;
    cnt_t       pos_reg;
    cnt_t       fill_m1;
    cnt_t       cur_m2;
    addr_t      rd_addr;
    addr_t      wr_addr;

    assign fill_m1 = fill_reg - cnt_t'(1);
    assign cur_m2  = cur_reg - cnt_t'(2);
    assign wr_addr = fill_reg[ADDR_W-1:0];

    // The read address is the top entry at start, else the entry below the scan.
    always_comb
    begin
        if (cmd.start)
        begin
            rd_addr = fill_m1[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = cur_m2[ADDR_W-1:0];
        end
    end

    // Fill count update.
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.push)
        begin
            fill_next = fill_reg + cnt_t'(1);
        end
        else if (cmd.pop)
        begin
            fill_next = fill_m1;
        end
    end

    // Scan counter holds the 1-based position of the entry in the read register.
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.start)
        begin
            cur_next = fill_reg;
        end
        else if (cmd.step)
        begin
            cur_next = cur_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Entry storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= value;
        end
        rd_reg <= mem[rd_addr];
    end

    // Request byte, scan counter and result registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.start || cmd.push)
        begin
            value_reg <= value;
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            data_reg   <= cmd.res_data ? rd_reg : 8'd0;
            pos_reg    <= cmd.res_pos ? cur_reg : '0;
        end
    end

    assign stat.full  = (fill_reg == cnt_t'(DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign stat.match = (rd_reg == value_reg);
    assign stat.last  = (cur_reg == cnt_t'(1));

    assign status   = status_reg;
    assign data     = data_reg;
    assign position = to_nibble(pos_reg);
    assign fill     = to_nibble(fill_reg);

endmodule

// ----- hw/rtl/lss_ctrl.sv -----
// ----------------------------------------------------------------------------
// lss_ctrl
// Controller: sequences each request and drives the result handshake.
// ----------------------------------------------------------------------------
module lss_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic [1:0]      kind,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  lss_pkg::stat_t  stat,
    output lss_pkg::cmd_t   cmd
);
    import lss_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       peek_reg, peek_next;
    logic       accept;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign accept    = req_valid && req_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        peek_next  = peek_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_PUSH)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = stat.full ? ST_OVERFLOW : ST_OK;
                        cmd.push       = !stat.full;
                        state_next     = S_OUT;
                    end
                    else if (stat.empty)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_EMPTY;
                        state_next     = S_OUT;
                    end
                    else if (kind == KIND_POP)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_OK;
                        cmd.pop        = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        peek_next  = (kind == KIND_PEEK);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // The read register holds the entry at the scan position.
                if (peek_reg)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_data   = 1'b1;
                    state_next     = S_OUT;
                end
                else if (stat.match)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_pos    = 1'b1;
                    state_next     = S_OUT;
                end
                else if (stat.last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NOTFOUND;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            peek_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            peek_reg  <= peek_next;
        end
    end

endmodule

// ----- hw/rtl/lifo_stack_with_search.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Byte stack of DEPTH entries with push, pop, peek and top-down search.
// ----------------------------------------------------------------------------
// Push, pop and any request refused on an empty stack: result valid in the cycle
//   after the transaction.
// Peek: result valid once the controller has passed through S_SCAN into S_OUT.
// Search: one entry per cycle walked through the single memory read port, from
//   the top down, until a match or the bottom entry; the result follows in S_OUT.
// One request is in flight at a time. Reset empties the stack, not its contents.
module lifo_stack_with_search (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] kind,
    input  logic [7:0] value,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic [1:0] status,
    output logic [7:0] data,
    output logic [3:0] position,
    output logic [3:0] fill
);
    import lss_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer for each transaction.
    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .kind      (kind),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage, counters and result registers.
    lss_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .cmd      (cmd),
        .stat     (stat),
        .status   (status),
        .data     (data),
        .position (position),
        .fill     (fill)
    );

endmodule
